@@ rtl/bsa_pkg.sv @@
// shared types and constants of the bitmap slot allocator
package bsa_pkg;

    localparam int MAX_SLOTS   = 64;
    localparam int DEF_SLOTS   = 64;
    localparam int FUNC_W      = 4;
    localparam int SLOT_W      = 6;
    localparam int COUNT_W     = 7;
    localparam int GROUP_W     = 8;
    localparam int GROUPS      = MAX_SLOTS / GROUP_W;
    localparam int GPOS_W      = $clog2(GROUP_W);
    localparam int GIDX_W      = $clog2(GROUPS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

    typedef logic [MAX_SLOTS-1:0] slot_vec_t;

    typedef enum logic [FUNC_W-1:0] {
        OP_READ      = 4'd0,
        OP_WRITE     = 4'd1,
        OP_SET       = 4'd2,
        OP_CLEAR     = 4'd3,
        OP_CLEAR_ALL = 4'd4,
        OP_LOW_FREE  = 4'd5,
        OP_LOW_USED  = 4'd6,
        OP_NEXT_FREE = 4'd7,
        OP_NEXT_USED = 4'd8,
        OP_ALLOC     = 4'd9,
        OP_RELEASE   = 4'd10,
        OP_NONE      = 4'd15
    } op_t;

    typedef struct packed {
        op_t       op;
        slot_vec_t onehot;
        slot_vec_t limit;
        logic      bit_in;
    } cmd_t;

    typedef struct packed {
        logic push;
        cmd_t cmd;
    } push_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } head_t;

endpackage

@@ rtl/bsa_if.sv @@
// request and response channel interfaces of the bitmap slot allocator
interface bsa_req_if;
    logic                      valid;
    logic                      ready;
    logic [bsa_pkg::FUNC_W-1:0] func;
    logic [bsa_pkg::SLOT_W-1:0] slot;
    logic                      bit_in;

    modport source (output valid, output func, output slot, output bit_in, input ready);
    modport sink   (input valid, input func, input slot, input bit_in, output ready);
endinterface

interface bsa_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        bit_out;
    logic                        found;
    logic [bsa_pkg::SLOT_W-1:0]  position;
    logic [bsa_pkg::COUNT_W-1:0] used_count;

    modport source (output valid, output bit_out, output found, output position,
                    output used_count, input ready);
    modport sink   (input valid, input bit_out, input found, input position,
                    input used_count, output ready);
endinterface

@@ rtl/bsa_front.sv @@
// front end: accepts request items, decodes func and builds slot masks
module bsa_front
(
    bsa_req_if.sink        req,
    input  logic           full,
    output bsa_pkg::push_t push
);

    bsa_pkg::op_t      op;
    bsa_pkg::slot_vec_t onehot;

    always_comb
    begin
        unique case (req.func)
            bsa_pkg::OP_READ:      op = bsa_pkg::OP_READ;
            bsa_pkg::OP_WRITE:     op = bsa_pkg::OP_WRITE;
            bsa_pkg::OP_SET:       op = bsa_pkg::OP_SET;
            bsa_pkg::OP_CLEAR:     op = bsa_pkg::OP_CLEAR;
            bsa_pkg::OP_CLEAR_ALL: op = bsa_pkg::OP_CLEAR_ALL;
            bsa_pkg::OP_LOW_FREE:  op = bsa_pkg::OP_LOW_FREE;
            bsa_pkg::OP_LOW_USED:  op = bsa_pkg::OP_LOW_USED;
            bsa_pkg::OP_NEXT_FREE: op = bsa_pkg::OP_NEXT_FREE;
            bsa_pkg::OP_NEXT_USED: op = bsa_pkg::OP_NEXT_USED;
            bsa_pkg::OP_ALLOC:     op = bsa_pkg::OP_ALLOC;
            bsa_pkg::OP_RELEASE:   op = bsa_pkg::OP_RELEASE;
            default:               op = bsa_pkg::OP_NONE;
        endcase
    end

    assign onehot = bsa_pkg::slot_vec_t'(1) << req.slot;

    always_comb
    begin
        push.push       = req.valid && !full;
        push.cmd.op     = op;
        push.cmd.onehot = onehot;
        push.cmd.bit_in = req.bit_in;
        // next searches look strictly above slot, others over the whole map
        if (op == bsa_pkg::OP_NEXT_FREE || op == bsa_pkg::OP_NEXT_USED)
        begin
            push.cmd.limit = ~bsa_pkg::slot_vec_t'(1) << req.slot;
        end
        else
        begin
            push.cmd.limit = '1;
        end
    end

    assign req.ready = !full;

endmodule

@@ rtl/bsa_queue.sv @@
// two-entry command queue between front end and back end
module bsa_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  bsa_pkg::push_t push,
    output logic           full,
    output bsa_pkg::head_t head,
    input  logic           pop
);

    bsa_pkg::cmd_t                      entry_reg [bsa_pkg::QUEUE_DEPTH];
    logic [bsa_pkg::QPTR_W-1:0]         wr_ptr_reg;
    logic [bsa_pkg::QPTR_W-1:0]         rd_ptr_reg;
    logic [bsa_pkg::QFILL_W-1:0]        fill_reg;
    logic [bsa_pkg::QFILL_W-1:0]        fill_next;
    logic                               do_push;
    logic                               do_pop;

    assign full    = (fill_reg == bsa_pkg::QFILL_W'(bsa_pkg::QUEUE_DEPTH));
    assign do_push = push.push && !full;
    assign do_pop  = pop && (fill_reg != '0);

    always_comb
    begin
        fill_next = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + bsa_pkg::QFILL_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - bsa_pkg::QFILL_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + bsa_pkg::QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + bsa_pkg::QPTR_W'(1);
            end
            fill_reg <= fill_next;
        end
    end

    assign head.valid = (fill_reg != '0);
    assign head.cmd   = entry_reg[rd_ptr_reg];

endmodule

@@ rtl/bsa_back.sv @@
// back end: occupancy map, two-step search and response register
module bsa_back
#(
    parameter int SLOTS = bsa_pkg::DEF_SLOTS
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  bsa_pkg::head_t head,
    output logic           pop,
    bsa_rsp_if.source      rsp
);

    localparam bsa_pkg::slot_vec_t VALID_MASK = bsa_pkg::slot_vec_t'({SLOTS{1'b1}});

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_COMMIT = 2'b10
    } state_t;

    state_t                            state_reg;
    state_t                            state_next;
    logic [SLOTS-1:0]                  occ_reg;
    logic [bsa_pkg::COUNT_W-1:0]       count_reg;
    bsa_pkg::cmd_t                     cmd_reg;
    logic [bsa_pkg::GROUPS-1:0]        grp_any_reg;
    logic [bsa_pkg::GROUPS-1:0]        grp_any_next;
    logic [bsa_pkg::GPOS_W-1:0]        grp_pos_reg  [bsa_pkg::GROUPS];
    logic [bsa_pkg::GPOS_W-1:0]        grp_pos_next [bsa_pkg::GROUPS];
    logic                              valid_reg;
    logic                              bit_out_reg;
    logic                              found_reg;
    logic [bsa_pkg::SLOT_W-1:0]        position_reg;

    bsa_pkg::slot_vec_t                occ_wide;
    bsa_pkg::slot_vec_t                cand;
    logic                              out_free;
    logic                              hit;
    logic                              old_bit;
    logic                              found;
    logic [bsa_pkg::GIDX_W-1:0]        gsel;
    logic [bsa_pkg::SLOT_W-1:0]        pos;
    bsa_pkg::slot_vec_t                pos_onehot;
    bsa_pkg::slot_vec_t                occ_next;
    logic [bsa_pkg::COUNT_W-1:0]       count_next;
    logic                              bit_out;

    function automatic logic [bsa_pkg::GPOS_W-1:0] lowest_in_group(
        input logic [bsa_pkg::GROUP_W-1:0] v);
        logic [bsa_pkg::GPOS_W-1:0] p;
        p = '0;
        for (int i = bsa_pkg::GROUP_W - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                p = bsa_pkg::GPOS_W'(i);
            end
        end
        return p;
    endfunction

    assign occ_wide = bsa_pkg::slot_vec_t'(occ_reg);
    assign out_free = !valid_reg || rsp.ready;
    assign pop      = (state_reg == ST_IDLE) && head.valid;

    // search candidates for the item at the queue head
    always_comb
    begin
        case (head.cmd.op) inside
            bsa_pkg::OP_LOW_FREE, bsa_pkg::OP_NEXT_FREE, bsa_pkg::OP_ALLOC:
                cand = ~occ_wide & VALID_MASK & head.cmd.limit;
            bsa_pkg::OP_LOW_USED, bsa_pkg::OP_NEXT_USED, bsa_pkg::OP_RELEASE:
                cand = occ_wide & head.cmd.limit;
            default:
                cand = '0;
        endcase
        for (int g = 0; g < bsa_pkg::GROUPS; g++)
        begin
            grp_any_next[g] = |cand[g*bsa_pkg::GROUP_W +: bsa_pkg::GROUP_W];
            grp_pos_next[g] = lowest_in_group(cand[g*bsa_pkg::GROUP_W +: bsa_pkg::GROUP_W]);
        end
    end

    // pick the lowest group with a candidate
    always_comb
    begin
        found = 1'b0;
        gsel  = '0;
        for (int g = bsa_pkg::GROUPS - 1; g >= 0; g--)
        begin
            if (grp_any_reg[g])
            begin
                found = 1'b1;
                gsel  = bsa_pkg::GIDX_W'(g);
            end
        end
        pos        = found ? {gsel, grp_pos_reg[gsel]} : '0;
        pos_onehot = bsa_pkg::slot_vec_t'(1) << pos;
    end

    assign hit     = |(cmd_reg.onehot & VALID_MASK);
    assign old_bit = |(occ_wide & cmd_reg.onehot);

    always_comb
    begin
        occ_next   = occ_wide;
        count_next = count_reg;
        bit_out    = 1'b0;
        case (cmd_reg.op)
            bsa_pkg::OP_READ:
            begin
                bit_out = old_bit;
            end
            bsa_pkg::OP_WRITE:
            begin
                if (hit)
                begin
                    occ_next = (occ_wide & ~cmd_reg.onehot)
                             | (cmd_reg.bit_in ? cmd_reg.onehot : '0);
                    if (cmd_reg.bit_in && !old_bit)
                    begin
                        count_next = count_reg + bsa_pkg::COUNT_W'(1);
                    end
                    else if (!cmd_reg.bit_in && old_bit)
                    begin
                        count_next = count_reg - bsa_pkg::COUNT_W'(1);
                    end
                end
            end
            bsa_pkg::OP_SET:
            begin
                occ_next = occ_wide | cmd_reg.onehot;
                if (hit && !old_bit)
                begin
                    count_next = count_reg + bsa_pkg::COUNT_W'(1);
                end
            end
            bsa_pkg::OP_CLEAR:
            begin
                occ_next = occ_wide & ~cmd_reg.onehot;
                if (old_bit)
                begin
                    count_next = count_reg - bsa_pkg::COUNT_W'(1);
                end
            end
            bsa_pkg::OP_CLEAR_ALL:
            begin
                occ_next   = '0;
                count_next = '0;
            end
            bsa_pkg::OP_ALLOC:
            begin
                if (found)
                begin
                    occ_next   = occ_wide | pos_onehot;
                    count_next = count_reg + bsa_pkg::COUNT_W'(1);
                end
            end
            bsa_pkg::OP_RELEASE:
            begin
                if (found)
                begin
                    occ_next   = occ_wide & ~pos_onehot;
                    count_next = count_reg - bsa_pkg::COUNT_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg     <= head.cmd;
            grp_any_reg <= grp_any_next;
            grp_pos_reg <= grp_pos_next;
        end
        if (state_reg == ST_COMMIT && out_free)
        begin
            bit_out_reg  <= bit_out;
            found_reg    <= found;
            position_reg <= pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            occ_reg   <= '0;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_COMMIT && out_free)
            begin
                occ_reg   <= occ_next[SLOTS-1:0];
                count_reg <= count_next;
                valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid      = valid_reg;
    assign rsp.bit_out    = bit_out_reg;
    assign rsp.found      = found_reg;
    assign rsp.position   = position_reg;
    assign rsp.used_count = count_reg;

endmodule

@@ rtl/bitmap_slot_allocator.sv @@
// top level of the bitmap slot allocator
//
//  channel  dir  handshake      payload
//  req      in   valid/ready    func, slot, bit_in
//  rsp      out  valid/ready    bit_out, found, position, used_count
//
// in the back end each item is first scanned by group, then picked and updated
// the back end sequencer takes no new item until the last one is committed
// a two-entry queue lets the front take items while the back end is busy
// reset clears the occupancy map, used count, queue and response valid flag
// a stalled response holds the back end in its commit step until taken
module bitmap_slot_allocator
#(
    parameter int SLOTS = bsa_pkg::DEF_SLOTS
)
(
    input  logic      clk,
    input  logic      rst_n,
    bsa_req_if.sink   req,
    bsa_rsp_if.source rsp
);

    bsa_pkg::push_t push;
    bsa_pkg::head_t head;
    logic           full;
    logic           pop;

    bsa_front u_front
    (
        .req  (req),
        .full (full),
        .push (push)
    );

    bsa_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .head  (head),
        .pop   (pop)
    );

    bsa_back #(
        .SLOTS (SLOTS)
    ) u_back
    (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .rsp   (rsp)
    );

endmodule
